// ----- design/bounded_ordered_array_engine_macros.svh -----
// Assertion macros for the bounded ordered array engine.
`ifndef BOUNDED_ORDERED_ARRAY_ENGINE_MACROS_SVH
`define BOUNDED_ORDERED_ARRAY_ENGINE_MACROS_SVH

// Same-cycle implication, checked on every rising edge out of reset.
`define BOAE_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("boae assertion failed");

// Next-cycle implication, checked on every rising edge out of reset.
`define BOAE_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("boae assertion failed");

`endif

// ----- design/boae_pkg.sv -----
// Shared types and codes of the bounded ordered array engine.
package boae_pkg;

  localparam int unsigned IdxW  = 5;
  localparam int unsigned ValW  = 32;
  localparam int unsigned CntW  = 5;

  typedef enum logic [2:0] {
    OP_APPEND = 3'd0,
    OP_INSERT = 3'd1,
    OP_DELETE = 3'd2,
    OP_READ   = 3'd3,
    OP_SORT   = 3'd4,
    OP_BSRCH  = 3'd5,
    OP_FIND   = 3'd6,
    OP_NONE   = 3'd7
  } op_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_RANGE    = 2'd1,
    ST_FULL     = 2'd2,
    ST_UNSORTED = 2'd3
  } status_t;

  localparam logic [IdxW-1:0] POS_NONE = 5'h1f;
  localparam logic [IdxW-1:0] POS_ZERO = 5'h00;

endpackage

// ----- design/bounded_ordered_array_engine.sv -----
// Top level of the bounded ordered array engine: sequencer around one entry memory.
// Usage:
// The input channel (in_*) carries one operation per item: in_tuser holds the
// operation code, in_tdata the index and the value. The result channel (out_*)
// returns exactly one item per operation with status in out_tuser and position,
// read data and entry count in out_tdata. cfg_wr_en writes the capacity limit;
// do so only while the block is idle.
// Append and the unused codes go straight to the result state; read waits for its
// memory read; insert and delete move entries one at a time; find visits entries in
// order until one matches or the count is reached; binary search first checks the
// store for ascending order (with two or more entries) and then halves the range;
// sort sweeps the entries above each slot for its minimum. Every step is bound by
// the single memory read port, whose data is registered and arrives in the cycle
// after the address.
// One item is worked on at a time; in_tready is high while the sequencer idles,
// so the next item is accepted in the cycle after its predecessor's result is loaded.
// A finished result sits in the output register, so the next item is accepted
// while it waits. If the receiver stalls and a second result is done, the
// sequencer holds it until the output register frees up.
// Reset (synchronous, rst_n low) empties the store, sets the capacity limit to
// 16 and drops out_tvalid. Entries above the count are never read, so no clearing pass.
module bounded_ordered_array_engine
  import boae_pkg::*;
#(
  parameter int unsigned DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [4:0]  cfg_wr_data,   // capacity_limit
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,      // index[4:0], value[36:5], zero pad
  input  logic [2:0]  in_tuser,      // operation[2:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,     // position[4:0], data[36:5], count[41:37], zero pad
  output logic [1:0]  out_tuser      // status[1:0]
);

  `include "bounded_ordered_array_engine_macros.svh"

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  // Largest count that fits both the memory and the 5-bit count field.
  localparam logic [CntW-1:0] CAP5 = CntW'((DEPTH < 31) ? DEPTH : 31);

  typedef enum logic [4:0] {
    S_IDLE, S_INS, S_INS_WR, S_DEL, S_DEL_WR, S_RD_WAIT,
    S_SORT_I, S_SORT_IW, S_SORT_J, S_SORT_C, S_SORT_E,
    S_CHK_FIRST, S_CHK_RD, S_CHK_CMP, S_BS, S_BS_CMP,
    S_FIND, S_FIND_CMP, S_DONE
  } state_t;

  state_t state_r, state_nxt;

  logic [CntW-1:0]        cap_r;
  logic [CntW-1:0]        cnt_r, cnt_nxt;
  logic [IdxW-1:0]        idx_r, idx_nxt;
  logic signed [ValW-1:0] val_r, val_nxt;
  logic [IdxW-1:0]        i_r, i_nxt;
  logic [IdxW-1:0]        j_r, j_nxt;
  logic [IdxW-1:0]        lo_r, lo_nxt;
  logic [IdxW-1:0]        hi_r, hi_nxt;
  logic signed [ValW-1:0] a_r, a_nxt;
  status_t                stat_r, stat_nxt;
  logic [IdxW-1:0]        pos_r, pos_nxt;
  logic [ValW-1:0]        data_r, data_nxt;

  logic                   out_valid_r;
  status_t                o_stat_r;
  logic [IdxW-1:0]        o_pos_r;
  logic [ValW-1:0]        o_data_r;
  logic [CntW-1:0]        o_cnt_r;

  // Memory port signals, pointers in entry units.
  logic [ValW-1:0]        mem [DEPTH];
  logic signed [ValW-1:0] rd_data_r;
  logic                   mem_we, mem_re;
  logic [IdxW-1:0]        wptr, rptr;
  logic [ValW-1:0]        mem_wdata;

  logic [CntW-1:0]        eff_cap;
  logic                   in_acc;
  logic [IdxW:0]          i_inc, j_inc;
  logic [IdxW-1:0]        mid;

  assign eff_cap = (cap_r > CAP5) ? CAP5 : cap_r;
  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign i_inc = {1'b0, i_r} + 6'd1;
  assign j_inc = {1'b0, j_r} + 6'd1;
  // Lower middle of the half-open range [lo, hi).
  assign mid = IdxW'(lo_r + ((hi_r - 5'd1 - lo_r) >> 1));

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[AW'(wptr)] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data_r <= mem[AW'(rptr)];
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    idx_nxt   = idx_r;
    val_nxt   = val_r;
    i_nxt     = i_r;
    j_nxt     = j_r;
    lo_nxt    = lo_r;
    hi_nxt    = hi_r;
    a_nxt     = a_r;
    stat_nxt  = stat_r;
    pos_nxt   = pos_r;
    data_nxt  = data_r;
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    wptr      = i_r;
    rptr      = i_r;
    mem_wdata = val_r;

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          idx_nxt  = in_tdata[4:0];
          val_nxt  = in_tdata[36:5];
          stat_nxt = ST_OK;
          pos_nxt  = POS_ZERO;
          data_nxt = '0;
          i_nxt    = '0;
          state_nxt = S_DONE;
          case (op_t'(in_tuser))
            OP_APPEND: begin
              if (cnt_r >= eff_cap) begin
                stat_nxt = ST_FULL;
              end else begin
                mem_we    = 1'b1;
                wptr      = cnt_r;
                mem_wdata = in_tdata[36:5];
                cnt_nxt   = cnt_r + 5'd1;
              end
            end
            OP_INSERT: begin
              if (in_tdata[4:0] > cnt_r) begin
                stat_nxt = ST_RANGE;
              end else if (cnt_r >= eff_cap) begin
                stat_nxt = ST_FULL;
              end else begin
                i_nxt     = cnt_r;
                state_nxt = S_INS;
              end
            end
            OP_DELETE: begin
              if (in_tdata[4:0] >= cnt_r) begin
                stat_nxt = ST_RANGE;
              end else begin
                i_nxt     = in_tdata[4:0];
                state_nxt = S_DEL;
              end
            end
            OP_READ: begin
              if (in_tdata[4:0] >= cnt_r) begin
                stat_nxt = ST_RANGE;
              end else begin
                mem_re    = 1'b1;
                rptr      = in_tdata[4:0];
                state_nxt = S_RD_WAIT;
              end
            end
            OP_SORT: begin
              if (cnt_r >= 5'd2) begin
                state_nxt = S_SORT_I;
              end
            end
            OP_BSRCH: begin
              pos_nxt = POS_NONE;
              lo_nxt  = '0;
              hi_nxt  = cnt_r;
              if (cnt_r >= 5'd2) begin
                mem_re    = 1'b1;
                rptr      = '0;
                state_nxt = S_CHK_FIRST;
              end else begin
                state_nxt = S_BS;
              end
            end
            OP_FIND: begin
              pos_nxt   = POS_NONE;
              state_nxt = S_FIND;
            end
            default: begin
            end
          endcase
        end
      end

      // Insert: move entries up from the top, then drop the value in.
      S_INS: begin
        if (i_r > idx_r) begin
          mem_re    = 1'b1;
          rptr      = i_r - 5'd1;
          state_nxt = S_INS_WR;
        end else begin
          mem_we    = 1'b1;
          wptr      = idx_r;
          mem_wdata = val_r;
          cnt_nxt   = cnt_r + 5'd1;
          state_nxt = S_DONE;
        end
      end
      S_INS_WR: begin
        mem_we    = 1'b1;
        wptr      = i_r;
        mem_wdata = rd_data_r;
        i_nxt     = i_r - 5'd1;
        state_nxt = S_INS;
      end

      // Delete: move entries down over the removed one.
      S_DEL: begin
        if (i_inc < {1'b0, cnt_r}) begin
          mem_re    = 1'b1;
          rptr      = IdxW'(i_inc);
          state_nxt = S_DEL_WR;
        end else begin
          cnt_nxt   = cnt_r - 5'd1;
          state_nxt = S_DONE;
        end
      end
      S_DEL_WR: begin
        mem_we    = 1'b1;
        wptr      = i_r;
        mem_wdata = rd_data_r;
        i_nxt     = IdxW'(i_inc);
        state_nxt = S_DEL;
      end

      S_RD_WAIT: begin
        data_nxt  = rd_data_r;
        state_nxt = S_DONE;
      end

      // Sort: a_r holds the running minimum for slot i while j sweeps above it.
      S_SORT_I: begin
        mem_re    = 1'b1;
        rptr      = i_r;
        state_nxt = S_SORT_IW;
      end
      S_SORT_IW: begin
        a_nxt     = rd_data_r;
        j_nxt     = IdxW'(i_inc);
        state_nxt = S_SORT_J;
      end
      S_SORT_J: begin
        mem_re    = 1'b1;
        rptr      = j_r;
        state_nxt = S_SORT_C;
      end
      S_SORT_C: begin
        if (rd_data_r < a_r) begin
          mem_we    = 1'b1;
          wptr      = j_r;
          mem_wdata = a_r;
          a_nxt     = rd_data_r;
        end
        j_nxt = IdxW'(j_inc);
        if (j_inc < {1'b0, cnt_r}) begin
          state_nxt = S_SORT_J;
        end else begin
          state_nxt = S_SORT_E;
        end
      end
      S_SORT_E: begin
        mem_we    = 1'b1;
        wptr      = i_r;
        mem_wdata = a_r;
        i_nxt     = IdxW'(i_inc);
        if ((i_inc + 6'd1) < {1'b0, cnt_r}) begin
          state_nxt = S_SORT_I;
        end else begin
          state_nxt = S_DONE;
        end
      end

      // Binary search, part one: walk the store to confirm ascending order.
      S_CHK_FIRST: begin
        a_nxt     = rd_data_r;
        i_nxt     = 5'd1;
        state_nxt = S_CHK_RD;
      end
      S_CHK_RD: begin
        mem_re    = 1'b1;
        rptr      = i_r;
        state_nxt = S_CHK_CMP;
      end
      S_CHK_CMP: begin
        if (rd_data_r < a_r) begin
          stat_nxt  = ST_UNSORTED;
          state_nxt = S_DONE;
        end else begin
          a_nxt = rd_data_r;
          i_nxt = IdxW'(i_inc);
          if (i_inc < {1'b0, cnt_r}) begin
            state_nxt = S_CHK_RD;
          end else begin
            state_nxt = S_BS;
          end
        end
      end

      // Binary search, part two: halve [lo, hi) until found or empty.
      S_BS: begin
        if (lo_r < hi_r) begin
          mem_re    = 1'b1;
          rptr      = mid;
          j_nxt     = mid;
          state_nxt = S_BS_CMP;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_BS_CMP: begin
        if (rd_data_r == val_r) begin
          pos_nxt   = j_r;
          state_nxt = S_DONE;
        end else if (rd_data_r < val_r) begin
          lo_nxt    = IdxW'(j_inc);
          state_nxt = S_BS;
        end else begin
          hi_nxt    = j_r;
          state_nxt = S_BS;
        end
      end

      S_FIND: begin
        if (i_r < cnt_r) begin
          mem_re    = 1'b1;
          rptr      = i_r;
          state_nxt = S_FIND_CMP;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_FIND_CMP: begin
        if (rd_data_r == val_r) begin
          pos_nxt   = i_r;
          state_nxt = S_DONE;
        end else begin
          i_nxt     = IdxW'(i_inc);
          state_nxt = S_FIND;
        end
      end

      S_DONE: begin
        if (!out_valid_r || out_tready) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      cap_r       <= 5'd16;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      if (cfg_wr_en) begin
        cap_r <= cfg_wr_data;
      end
      if (state_r == S_DONE && (!out_valid_r || out_tready)) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
    idx_r  <= idx_nxt;
    val_r  <= val_nxt;
    i_r    <= i_nxt;
    j_r    <= j_nxt;
    lo_r   <= lo_nxt;
    hi_r   <= hi_nxt;
    a_r    <= a_nxt;
    stat_r <= stat_nxt;
    pos_r  <= pos_nxt;
    data_r <= data_nxt;
    if (state_r == S_DONE && (!out_valid_r || out_tready)) begin
      o_stat_r <= stat_r;
      o_pos_r  <= pos_r;
      o_data_r <= data_r;
      o_cnt_r  <= cnt_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = o_stat_r;
  assign out_tdata  = {6'd0, o_cnt_r, o_data_r, o_pos_r};

  `BOAE_ASSERT_NOW(a_count_bound, 1'b1, cnt_r <= CAP5)
  `BOAE_ASSERT_NEXT(a_accept_leaves_idle, in_acc, state_r != S_IDLE)
  `BOAE_ASSERT_NOW(a_write_within_count, mem_we, wptr <= cnt_r)

endmodule

// ----- sim/tb_bounded_ordered_array_engine.sv -----
// Self-checking testbench for the bounded ordered array engine.
`timescale 1ns / 100ps

module tb_bounded_ordered_array_engine
  import boae_pkg::*;
();

  localparam int unsigned STORE_DEPTH = 16;
  localparam int unsigned CYCLE_LIMIT = 1500000;

  // One expected result item, field by field.
  typedef struct {
    status_t     status;
    logic [4:0]  position;
    logic [31:0] data;
    logic [4:0]  count;
  } result_t;

  logic        clk;
  logic        rst_n;
  logic        cfg_wr_en;
  logic [4:0]  cfg_wr_data;
  logic        in_tvalid;
  logic        in_tready;
  logic [39:0] in_tdata;
  logic [2:0]  in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [47:0] out_tdata;
  logic [1:0]  out_tuser;

  // Shadow copy of the store, the count and the capacity register.
  logic [31:0] shadow_entries [STORE_DEPTH];
  int unsigned shadow_count;
  int unsigned shadow_capacity;

  result_t     pending_results [$];
  int unsigned mismatch_count;
  int unsigned cycle_count;
  int unsigned stall_left;
  bit          idle_enable;

  bounded_ordered_array_engine #(.DEPTH(STORE_DEPTH)) uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  // Signed comparison of two stored patterns.
  function automatic bit entry_less(logic [31:0] a, logic [31:0] b);
    return $signed(a) < $signed(b);
  endfunction

  // Apply one operation to the shadow store and return the result it must produce.
  function automatic result_t apply_operation(op_t op, logic [4:0] idx, logic [31:0] val);
    result_t     r;
    int unsigned cap;
    int unsigned n;
    int unsigned lo;
    int unsigned hi;
    int unsigned mid;
    logic [31:0] tmp;
    bit          ordered;
    r.status   = ST_OK;
    r.position = POS_ZERO;
    r.data     = '0;
    n   = shadow_count;
    cap = (shadow_capacity < STORE_DEPTH) ? shadow_capacity : STORE_DEPTH;
    case (op)
      OP_APPEND: begin
        if (n >= cap) r.status = ST_FULL;
        else begin
          shadow_entries[n] = val;
          shadow_count = n + 1;
        end
      end
      OP_INSERT: begin
        if (idx > n) r.status = ST_RANGE;
        else if (n >= cap) r.status = ST_FULL;
        else begin
          for (int i = n; i > idx; i--) shadow_entries[i] = shadow_entries[i-1];
          shadow_entries[idx] = val;
          shadow_count = n + 1;
        end
      end
      OP_DELETE: begin
        if (idx >= n) r.status = ST_RANGE;
        else begin
          for (int i = idx; i + 1 < n; i++) shadow_entries[i] = shadow_entries[i+1];
          shadow_count = n - 1;
        end
      end
      OP_READ: begin
        if (idx >= n) r.status = ST_RANGE;
        else r.data = shadow_entries[idx];
      end
      OP_SORT: begin
        for (int i = 0; i + 1 < n; i++)
          for (int j = i + 1; j < n; j++)
            if (entry_less(shadow_entries[j], shadow_entries[i])) begin
              tmp = shadow_entries[i];
              shadow_entries[i] = shadow_entries[j];
              shadow_entries[j] = tmp;
            end
      end
      OP_BSRCH: begin
        r.position = POS_NONE;
        ordered = 1'b1;
        for (int i = 0; i + 1 < n; i++)
          if (entry_less(shadow_entries[i+1], shadow_entries[i])) ordered = 1'b0;
        if (!ordered) r.status = ST_UNSORTED;
        else begin
          // Half-open range, lower middle.
          lo = 0;
          hi = n;
          while (lo < hi) begin
            mid = lo + (hi - 1 - lo) / 2;
            if (shadow_entries[mid] == val) begin
              r.position = mid[4:0];
              break;
            end else if (entry_less(shadow_entries[mid], val)) lo = mid + 1;
            else hi = mid;
          end
        end
      end
      OP_FIND: begin
        r.position = POS_NONE;
        for (int i = 0; i < n; i++)
          if (shadow_entries[i] == val) begin
            r.position = i[4:0];
            break;
          end
      end
      default: ;
    endcase
    r.count = shadow_count[4:0];
    return r;
  endfunction

  // Random idle burst, sometimes, with the input withdrawn.
  task automatic maybe_idle();
    if (idle_enable && $urandom_range(3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(18, 1)) @(posedge clk);
    end
  endtask

  // Offer one item and wait until the block takes it; the caller's next item
  // or an idle burst replaces it.
  task automatic send_item(op_t op, logic [4:0] idx, logic [31:0] val);
    maybe_idle();
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {3'b000, val, idx};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pending_results.push_back(apply_operation(op, idx, val));
  endtask

  // Withdraw the input, wait until every result is back, then settle.
  task automatic drain();
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (600) @(posedge clk);
  endtask

  task automatic write_capacity(logic [4:0] cap);
    drain();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= cap;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    shadow_capacity = cap;
  endtask

  function automatic logic [31:0] random_value();
    case ($urandom_range(5))
      0:       return 32'h8000_0000;
      1:       return 32'h7fff_ffff;
      2:       return $urandom_range(7) - 3;
      default: return $urandom;
    endcase
  endfunction

  // Directed: boundaries, every operation, and the error paths.
  task automatic test_directed();
    send_item(OP_FIND, 5'd0, 32'd5);           // search on an empty store
    send_item(OP_BSRCH, 5'd0, 32'd5);
    send_item(OP_SORT, 5'd0, 32'd0);           // sort with no entries
    send_item(OP_READ, 5'd0, 32'd0);           // read beyond the count
    send_item(OP_DELETE, 5'd0, 32'd0);
    send_item(OP_APPEND, 5'd0, 32'h7fff_ffff);
    send_item(OP_SORT, 5'd0, 32'd0);           // sort with a single entry
    send_item(OP_APPEND, 5'd0, 32'h8000_0000);
    send_item(OP_INSERT, 5'd3, 32'd1);         // insert beyond the count
    send_item(OP_INSERT, 5'd2, 32'hffff_ffff); // insert at the count appends
    send_item(OP_INSERT, 5'd0, 32'd0);
    send_item(OP_BSRCH, 5'd0, 32'd0);          // unsorted store
    send_item(OP_FIND, 5'd0, 32'h8000_0000);
    send_item(OP_SORT, 5'd0, 32'd0);
    send_item(OP_BSRCH, 5'd0, 32'h7fff_ffff);
    send_item(OP_BSRCH, 5'd0, 32'd12345);
    send_item(OP_READ, 5'd3, 32'd0);
    send_item(OP_READ, 5'd31, 32'd0);
    send_item(OP_NONE, 5'd31, 32'hffff_ffff);   // unused code is ignored
    send_item(OP_DELETE, 5'd1, 32'd0);
    send_item(OP_DELETE, 5'd31, 32'd0);
  endtask

  // Capacity changes, including zero, a value below the count and the maximum.
  task automatic test_capacity();
    write_capacity(5'd2);
    send_item(OP_APPEND, 5'd0, 32'd9);         // count already above the limit
    send_item(OP_INSERT, 5'd0, 32'd9);
    send_item(OP_DELETE, 5'd0, 32'd0);
    send_item(OP_APPEND, 5'd0, 32'd9);
    write_capacity(5'd0);
    send_item(OP_APPEND, 5'd0, 32'd1);
    write_capacity(5'd31);
    for (int i = 0; i < 18; i++) send_item(OP_APPEND, 5'd0, random_value());
    send_item(OP_INSERT, 5'd16, 32'd1);
    send_item(OP_SORT, 5'd0, 32'd0);
    send_item(OP_BSRCH, 5'd0, shadow_entries[15]);
    send_item(OP_READ, 5'd15, 32'd0);
  endtask

  // Random operations in phases with different capacities.
  task automatic test_random(int unsigned items);
    op_t         op;
    logic [4:0]  idx;
    logic [31:0] val;
    for (int k = 0; k < items; k++) begin
      if (k % 110 == 0)
        write_capacity(((k / 110) % 2) != 0 ? 5'd16 : 5'($urandom_range(16, 3)));
      if (k > items * 4 / 5) idle_enable = 1'b0;
      op = op_t'($urandom_range(7));
      // Keep the store busy: favor growth while it is nearly empty.
      if (shadow_count < 4 && $urandom_range(1)) op = OP_APPEND;
      if (shadow_count > 0 && $urandom_range(4) != 0)
        idx = 5'($urandom_range(shadow_count));
      else
        idx = 5'($urandom);
      if ((op == OP_FIND || op == OP_BSRCH) && shadow_count > 0 && $urandom_range(1))
        val = shadow_entries[$urandom_range(shadow_count - 1)];
      else
        val = random_value();
      send_item(op, idx, val);
    end
  endtask

  // Receiver stalls in bursts and compares each result with the oldest expectation.
  always @(posedge clk) begin
    result_t want;
    cycle_count <= cycle_count + 1;
    if (!rst_n) begin
      out_tready <= 1'b0;
      stall_left <= 0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (pending_results.size() == 0) begin
          mismatch_count <= mismatch_count + 1;
          if (mismatch_count < 10) $display("unexpected result item %h", out_tdata);
        end else begin
          want = pending_results.pop_front();
          if (out_tuser !== want.status || out_tdata[4:0] !== want.position ||
              out_tdata[36:5] !== want.data || out_tdata[41:37] !== want.count ||
              out_tdata[47:42] !== 6'd0) begin
            mismatch_count <= mismatch_count + 1;
            if (mismatch_count < 10)
              $display("mismatch: want st=%0d pos=%h data=%h cnt=%0d",
                       want.status, want.position, want.data, want.count,
                       ", got st=%0d pos=%h data=%h cnt=%0d",
                       out_tuser, out_tdata[4:0], out_tdata[36:5], out_tdata[41:37]);
          end
        end
      end
      if (stall_left != 0) begin
        out_tready <= 1'b0;
        stall_left <= stall_left - 1;
      end else if (idle_enable && $urandom_range(5) == 0) begin
        out_tready <= 1'b0;
        stall_left <= $urandom_range(17, 0);
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // Timeout watchdog.
  always @(posedge clk) begin
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    rst_n          = 1'b0;
    cfg_wr_en      = 1'b0;
    cfg_wr_data    = '0;
    in_tvalid      = 1'b0;
    in_tdata       = '0;
    in_tuser       = OP_NONE;
    mismatch_count = 0;
    cycle_count    = 0;
    idle_enable    = 1'b1;
    shadow_count   = 0;
    shadow_capacity = 16;
    foreach (shadow_entries[i]) shadow_entries[i] = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_capacity();
    test_random(520);
    drain();
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
